/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stage pitch quantizer.
// No dependencies; used by the front, queue, back and top-level modules.
package spq_pkg;

    localparam int unsigned VOLT_W = 16;
    localparam int unsigned RUN_W  = 19;

    localparam logic [3:0]        LAST_SEMI   = 4'd11;
    // floor(x/12) = (x * RECIP_12) >> RECIP_SH, exact for x < 2^17
    localparam logic [16:0]       RECIP_12    = 17'd87382;
    localparam int unsigned       RECIP_SH    = 20;
    localparam logic [VOLT_W-1:0] VOLT_MAX    = 16'hFFFF;
    localparam logic [RUN_W-1:0]  CASCADE_MAX = 19'h7FFFF;

    localparam logic [31:0] GAIN_RST    = 32'd1079442;
    localparam logic [11:0] CPV_RST     = 12'd1000;
    localparam logic [6:0]  RANGE_RST   = 7'd60;
    localparam logic [11:0] MAX_DAC_RST = 12'd4095;

    typedef enum logic [2:0] {
        CFG_GAIN    = 3'd0,
        CFG_MASK_A  = 3'd1,
        CFG_MASK_B  = 3'd2,
        CFG_MASK_C  = 3'd3,
        CFG_CPV     = 3'd4,
        CFG_RANGE   = 3'd5,
        CFG_MAX_DAC = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] gain;
        logic [11:0] mask_a;
        logic [11:0] mask_b;
        logic [11:0] mask_c;
        logic [11:0] cpv;
        logic [6:0]  sem_range;
        logic [11:0] max_dac;
    } t_cfg;

    // One classified stage, as queued between front and back
    typedef struct packed {
        logic [11:0] slider;
        logic [11:0] scale;
        logic        active;
        logic        pass;
        logic [11:0] mask;
        logic        restart;
        logic        last;
        logic [2:0]  stage_num;
    } t_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_SEARCH,
        BK_PICK,
        BK_OUT
    } t_back_state;

endpackage

/* sv/spq_front.sv */
`timescale 1ns / 1ps
// Front end: takes input beats, tracks the stage index and classifies each stage.
// Depends on spq_pkg.
module spq_front #(
    parameter int NUM_STAGES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spq_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [23:0]          i_data,   // slider, scale_slider
    input  logic [3:0]           i_user,   // active_a, active_b, active_c, prev_jack_plugged
    input  logic                 i_full,
    output logic                 o_push,
    output spq_pkg::t_item       o_item
);

    localparam int CW = $clog2(NUM_STAGES);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW+2:0] w_pad;
    logic          w_last;
    logic          w_act_a, w_act_b, w_act_c;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign w_act_a = i_user[0];
    assign w_act_b = i_user[1];
    assign w_act_c = i_user[2];
    assign w_pad   = {3'b000, r_cnt};
    assign w_last  = (r_cnt == CW'(NUM_STAGES - 1));

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            n_cnt = w_last ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        o_item.slider    = i_data[11:0];
        o_item.scale     = i_data[23:12];
        o_item.active    = w_act_a || w_act_b || w_act_c;
        o_item.mask      = (w_act_a ? i_cfg.mask_a : 12'd0)
                         | (w_act_b ? i_cfg.mask_b : 12'd0)
                         | (w_act_c ? i_cfg.mask_c : 12'd0);
        // an active channel with no notes enabled disables snapping
        o_item.pass      = (w_act_a && (i_cfg.mask_a == 12'd0))
                         || (w_act_b && (i_cfg.mask_b == 12'd0))
                         || (w_act_c && (i_cfg.mask_c == 12'd0));
        o_item.restart   = (r_cnt == '0) || i_user[3];
        o_item.last      = w_last;
        o_item.stage_num = w_pad[2:0];
    end

endmodule

/* sv/spq_fifo.sv */
`timescale 1ns / 1ps
// Two-entry queue of classified stages between front and back.
// Depends on spq_pkg.
module spq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spq_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output spq_pkg::t_item o_item
);

    spq_pkg::t_item r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           n_wp, n_rp;
    logic [1:0]     n_cnt;
    logic           w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* sv/spq_back.sv */
`timescale 1ns / 1ps
// Back end: scales a stage, snaps an active, non-pass stage to the scale one semitone
// per cycle, updates the cascade and holds the result beat. Depends on spq_pkg.
module spq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spq_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    input  spq_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_stage,
    output logic [15:0]    o_quant,
    output logic [11:0]    o_casc,
    output logic           o_last
);

    spq_pkg::t_back_state r_state, n_state;

    spq_pkg::t_item r_item, n_item;
    logic [23:0]    r_p24, n_p24;
    logic [15:0]    r_v, n_v;
    logic [6:0]     r_s, n_s;
    logic [3:0]     r_n, n_n;
    logic [15:0]    r_base, n_base;
    logic [15:0]    r_acc, n_acc;
    logic [15:0]    r_lower, n_lower;
    logic [15:0]    r_upper, n_upper;
    logic           r_have_up, n_have_up;
    logic [18:0]    r_run, n_run;
    logic           r_ovalid, n_ovalid;
    logic [2:0]     r_o_stage, n_o_stage;
    logic [15:0]    r_o_quant, n_o_quant;
    logic [11:0]    r_o_casc, n_o_casc;
    logic           r_o_last, n_o_last;

    logic [55:0] w_prod;
    logic [15:0] w_vsat;
    logic [32:0] w_rprod;
    logic [11:0] w_off;
    logic [15:0] w_q;
    logic        w_bit;
    logic [15:0] w_lo_gap, w_up_gap;
    logic        w_out_free;
    logic [19:0] w_sum;
    logic [18:0] w_run_next;
    logic [11:0] w_casc;

    assign w_prod   = 56'(r_p24) * 56'(i_cfg.gain);
    assign w_vsat   = (|w_prod[55:48]) ? spq_pkg::VOLT_MAX : w_prod[47:32];
    // semitone offset floor(n*cpv/12) by reciprocal multiply
    assign w_rprod  = 33'(r_acc) * 33'(spq_pkg::RECIP_12);
    assign w_off    = w_rprod[31:spq_pkg::RECIP_SH];
    assign w_q      = r_base + 16'(w_off);
    assign w_bit    = r_item.mask[r_n];
    assign w_lo_gap = r_v - r_lower;
    assign w_up_gap = r_upper - r_v;

    assign w_out_free = !r_ovalid || i_ready;
    assign w_sum      = {1'b0, r_run} + 20'(r_v);
    assign w_run_next = r_item.restart ? 19'(r_v)
                      : (w_sum[19] ? spq_pkg::CASCADE_MAX : w_sum[18:0]);
    assign w_casc     = (w_run_next < 19'(i_cfg.max_dac)) ? w_run_next[11:0] : i_cfg.max_dac;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_p24     = r_p24;
        n_v       = r_v;
        n_s       = r_s;
        n_n       = r_n;
        n_base    = r_base;
        n_acc     = r_acc;
        n_lower   = r_lower;
        n_upper   = r_upper;
        n_have_up = r_have_up;
        n_run     = r_run;
        n_ovalid  = r_ovalid && !i_ready;
        n_o_stage = r_o_stage;
        n_o_quant = r_o_quant;
        n_o_casc  = r_o_casc;
        n_o_last  = r_o_last;
        o_pop     = 1'b0;

        unique case (r_state)
            spq_pkg::BK_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_state = spq_pkg::BK_MUL;
                end
            end
            spq_pkg::BK_MUL: begin
                n_p24   = 24'(r_item.slider) * 24'(r_item.scale);
                n_state = spq_pkg::BK_SCALE;
            end
            spq_pkg::BK_SCALE: begin
                n_s       = '0;
                n_n       = '0;
                n_base    = '0;
                n_acc     = '0;
                n_lower   = '0;
                n_upper   = '0;
                n_have_up = 1'b0;
                if (!r_item.active) begin
                    n_v     = '0;
                    n_state = spq_pkg::BK_OUT;
                end else begin
                    n_v     = w_vsat;
                    n_state = r_item.pass ? spq_pkg::BK_OUT : spq_pkg::BK_SEARCH;
                end
            end
            spq_pkg::BK_SEARCH: begin
                if (w_bit && (w_q > r_v)) begin
                    // first enabled note above the voltage ends the walk
                    n_upper   = w_q;
                    n_have_up = 1'b1;
                    n_state   = spq_pkg::BK_PICK;
                end else begin
                    if (w_bit) begin
                        n_lower = w_q;
                    end
                    if (r_s == i_cfg.sem_range) begin
                        n_state = spq_pkg::BK_PICK;
                    end else begin
                        n_s = r_s + 1'b1;
                        if (r_n == spq_pkg::LAST_SEMI) begin
                            n_n    = '0;
                            n_acc  = '0;
                            n_base = r_base + 16'(i_cfg.cpv);
                        end else begin
                            n_n   = r_n + 1'b1;
                            n_acc = r_acc + 16'(i_cfg.cpv);
                        end
                    end
                end
            end
            spq_pkg::BK_PICK: begin
                // ties resolve to the lower note
                n_v     = (r_have_up && (w_lo_gap > w_up_gap)) ? r_upper : r_lower;
                n_state = spq_pkg::BK_OUT;
            end
            spq_pkg::BK_OUT: begin
                if (w_out_free) begin
                    n_run     = w_run_next;
                    n_ovalid  = 1'b1;
                    n_o_stage = r_item.stage_num;
                    n_o_quant = r_v;
                    n_o_casc  = w_casc;
                    n_o_last  = r_item.last;
                    n_state   = spq_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spq_pkg::BK_IDLE;
            r_run    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_p24     <= n_p24;
        r_v       <= n_v;
        r_s       <= n_s;
        r_n       <= n_n;
        r_base    <= n_base;
        r_acc     <= n_acc;
        r_lower   <= n_lower;
        r_upper   <= n_upper;
        r_have_up <= n_have_up;
        r_o_stage <= n_o_stage;
        r_o_quant <= n_o_quant;
        r_o_casc  <= n_o_casc;
        r_o_last  <= n_o_last;
    end

    assign o_valid = r_ovalid;
    assign o_stage = r_o_stage;
    assign o_quant = r_o_quant;
    assign o_casc  = r_o_casc;
    assign o_last  = r_o_last;

endmodule

/* sv/stage_pitch_quantize_cascade_unit.sv */
`timescale 1ns / 1ps
// An inactive or pass-through stage goes from the queue through the back end's
// idle, multiply, scale and output states; a snapped stage also walks the semitones
// up to sem_range, one step per cycle, before the pick and output states.
// The two-beat queue lets the front accept until it fills while the back end works.
// Synchronous active-low reset: registers to defaults, stage count and cascade to 0.
module stage_pitch_quantize_cascade_unit #(
    parameter int NUM_STAGES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [11:0] slider, [23:12] scale_slider
    input  logic [3:0]  s_axis_tuser,  // [0] active_a, [1] active_b, [2] active_c,
                                       // [3] prev_jack_plugged
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [2:0] stage_number, [18:3] quantized_count,
                                       // [30:19] cascaded_count, [31] zero
    output logic        m_axis_tlast   // last_stage
);

    spq_pkg::t_cfg  r_cfg;
    spq_pkg::t_item w_front_item, w_queue_item;
    logic           w_push, w_full, w_q_valid, w_pop;
    logic [2:0]     w_stage;
    logic [15:0]    w_quant;
    logic [11:0]    w_casc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain      <= spq_pkg::GAIN_RST;
            r_cfg.mask_a    <= '0;
            r_cfg.mask_b    <= '0;
            r_cfg.mask_c    <= '0;
            r_cfg.cpv       <= spq_pkg::CPV_RST;
            r_cfg.sem_range <= spq_pkg::RANGE_RST;
            r_cfg.max_dac   <= spq_pkg::MAX_DAC_RST;
        end else if (i_cfg_we) begin
            unique case (spq_pkg::t_cfg_idx'(i_cfg_addr))
                spq_pkg::CFG_GAIN:    r_cfg.gain      <= i_cfg_wdata;
                spq_pkg::CFG_MASK_A:  r_cfg.mask_a    <= i_cfg_wdata[11:0];
                spq_pkg::CFG_MASK_B:  r_cfg.mask_b    <= i_cfg_wdata[11:0];
                spq_pkg::CFG_MASK_C:  r_cfg.mask_c    <= i_cfg_wdata[11:0];
                spq_pkg::CFG_CPV:     r_cfg.cpv       <= i_cfg_wdata[11:0];
                spq_pkg::CFG_RANGE:   r_cfg.sem_range <= i_cfg_wdata[6:0];
                spq_pkg::CFG_MAX_DAC: r_cfg.max_dac   <= i_cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    spq_front #(
        .NUM_STAGES (NUM_STAGES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    spq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_queue_item)
    );

    spq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_q_valid),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_stage (w_stage),
        .o_quant (w_quant),
        .o_casc  (w_casc),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_casc, w_quant, w_stage};

endmodule

/* sv/spq_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the stage pitch quantizer, bound to the top level.
// Depends on stage_pitch_quantize_cascade_unit only through its ports.
module spq_checker #(
    parameter int NUM_STAGES = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    localparam int CW = $clog2(NUM_STAGES);

    logic [2:0]    r_inflight;
    logic [CW-1:0] r_exp;
    logic [CW+2:0] w_exp_pad;
    logic          w_in_beat, w_out_beat;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;
    assign w_exp_pad  = {3'b000, r_exp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_exp      <= '0;
        end else begin
            r_inflight <= r_inflight + {2'b00, w_in_beat} - {2'b00, w_out_beat};
            if (w_out_beat) begin
                r_exp <= (r_exp == CW'(NUM_STAGES - 1)) ? '0 : r_exp + 1'b1;
            end
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat shown right after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != 3'd0)
        else $error("result beat without an accepted stage");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] == w_exp_pad[2:0])
        else $error("stage number out of sequence");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == (r_exp == CW'(NUM_STAGES - 1)))
        else $error("frame end flag on wrong stage");

endmodule

bind stage_pitch_quantize_cascade_unit spq_checker #(
    .NUM_STAGES (NUM_STAGES)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
